FILE: src/c_like_text_tokenizer_macros.svh
// Assertion macros for the text tokenizer.
// Used by the top level only; needs signals clock and reset in scope.
`ifndef C_LIKE_TEXT_TOKENIZER_MACROS_SVH
`define C_LIKE_TEXT_TOKENIZER_MACROS_SVH
// same-cycle implication
`define CTT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/ctt_pkg.sv
// Shared types, codes and scan functions of the text tokenizer.
// No dependencies.
package ctt_pkg;

   localparam int MaxToken = 1024;
   localparam int TokLenW  = $clog2(MaxToken) + 1;
   localparam int MaxRes   = 4;
   localparam int QDepth   = 4;

   localparam logic [2:0] KindChar  = 3'd0;
   localparam logic [2:0] KindEnd   = 3'd1;
   localparam logic [2:0] KindEol   = 3'd2;
   localparam logic [2:0] KindError = 3'd3;
   localparam logic [2:0] KindEos   = 3'd4;

   localparam logic [1:0] TypeIdent = 2'd0;
   localparam logic [1:0] TypeStr   = 2'd1;
   localparam logic [1:0] TypeInt   = 2'd2;
   localparam logic [1:0] TypeReal  = 2'd3;

   localparam logic [2:0] ErrEndComment = 3'd0;
   localparam logic [2:0] ErrEndQuote   = 3'd1;
   localparam logic [2:0] ErrNlQuote    = 3'd2;
   localparam logic [2:0] ErrNlChar     = 3'd3;
   localparam logic [2:0] ErrTokLong    = 3'd4;
   localparam logic [2:0] ErrStrLong    = 3'd5;

   localparam logic [23:0] LineMax = 24'hFFFFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_LINE, S_BLK_OPEN, S_BLK, S_BLK_STAR, S_STR, S_CHR_OPEN,
      S_CHR_ESC, S_CHR_CLOSE, S_HEX_X, S_HEX, S_NUM, S_IDENT, S_OP2
   } scan_state_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_char;
      logic [1:0]  token_type;
      logic [2:0]  error_code;
      logic [23:0] line_number;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  ch;
      logic [1:0]  ttype;
      logic [2:0]  err;
      logic [23:0] line;
   } res_type;

   typedef struct packed {
      logic [2:0]          cnt;
      res_type [MaxRes-1:0] res;
   } bundle_type;

   typedef struct packed {
      scan_state_type     st;
      logic [TokLenW-1:0] tl;
      logic               pt;
      logic               esc;
      logic [23:0]        line;
      bundle_type         bnd;
   } ctx_type;

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_single_op(logic [7:0] c);
      return c == "{" || c == "}" || c == "[" || c == "]" || c == "(" || c == ")" ||
             c == "," || c == "." || c == ";" || c == "!" || c == 8'h5C || c == "#";
   endfunction

   function automatic logic is_double_op(logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "|" ||
             c == "&" || c == "^" || c == "=" || c == ">" || c == "<";
   endfunction

   function automatic logic is_full(logic [TokLenW-1:0] tl);
      return ({1'b0, tl} + (TokLenW+1)'(1)) >= (TokLenW+1)'(MaxToken);
   endfunction

   function automatic ctx_type put(ctx_type x, logic [2:0] kind, logic [7:0] ch,
                                   logic [1:0] ttype, logic [2:0] err);
      ctx_type r;
      r = x;
      if (x.bnd.cnt < 3'(MaxRes)) begin
         r.bnd.res[x.bnd.cnt[1:0]] = '{kind: kind, ch: ch, ttype: ttype, err: err,
                                       line: x.line};
         r.bnd.cnt = x.bnd.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic ctx_type end_token(ctx_type x, logic [1:0] ttype);
      ctx_type r;
      r = put(x, KindEnd, 8'd0, ttype, 3'd0);
      r.st = S_IDLE;
      return r;
   endfunction

   function automatic ctx_type newline(ctx_type x, logic rn);
      ctx_type r;
      r = x;
      if (r.line < LineMax) r.line = r.line + 24'd1;
      if (rn) r = put(r, KindEol, 8'd0, 2'd0, 3'd0);
      return r;
   endfunction

   // scan one byte between tokens; a fresh token never overflows
   function automatic ctx_type idle_byte(ctx_type x, logic [7:0] c, logic [7:0] n,
                                         logic rn);
      ctx_type r;
      r = x;
      r.st = S_IDLE;
      r.tl = '0;
      r.pt = 1'b0;
      r.esc = 1'b0;
      if (c == 8'h0A) begin
         r = newline(r, rn);
      end else if (c <= 8'd32) begin
         r.st = S_IDLE;
      end else if (c == "/" && n == "/") begin
         r.st = S_LINE;
      end else if (c == "/" && n == "*") begin
         r.st = S_BLK_OPEN;
      end else if (c == 8'h22) begin
         r.st = S_STR;
      end else if (c == 8'h27) begin
         r = put(r, KindChar, c, 2'd0, 3'd0);
         r.st = S_CHR_OPEN;
      end else if (c == "0" && n == "x") begin
         r = put(r, KindChar, c, 2'd0, 3'd0);
         r.tl = TokLenW'(1);
         r.st = S_HEX_X;
      end else if (is_digit(c) || (c == "-" && is_digit(n))) begin
         r.tl = TokLenW'(1);
         r = put(r, KindChar, c, 2'd0, 3'd0);
         if (is_digit(n) || n == ".") r.st = S_NUM;
         else r = end_token(r, TypeInt);
      end else if (is_single_op(c)) begin
         r = put(r, KindChar, c, 2'd0, 3'd0);
         r = end_token(r, TypeIdent);
      end else if (is_double_op(c)) begin
         r = put(r, KindChar, c, 2'd0, 3'd0);
         if (n == "=") r.st = S_OP2;
         else r = end_token(r, TypeIdent);
      end else begin
         r.tl = TokLenW'(1);
         r = put(r, KindChar, c, 2'd0, 3'd0);
         if (n <= 8'd32 || is_single_op(n) || is_double_op(n)) r = end_token(r, TypeIdent);
         else r.st = S_IDENT;
      end
      return r;
   endfunction

   function automatic ctx_type fail_restart(ctx_type x, logic [2:0] code, logic [7:0] c,
                                            logic [7:0] n, logic rn);
      ctx_type r;
      r = put(x, KindError, 8'd0, 2'd0, code);
      r.st = S_IDLE;
      return idle_byte(r, c, n, rn);
   endfunction

   function automatic ctx_type scan(ctx_type x, logic [7:0] c, logic [7:0] n, logic rn);
      ctx_type r;
      r = x;
      case (x.st)
         S_LINE: begin
            if (c == 8'h0A) r = idle_byte(r, c, n, rn);
         end
         S_BLK_OPEN: r.st = S_BLK;
         S_BLK, S_BLK_STAR: begin
            if (x.st == S_BLK_STAR && c == "/") r.st = S_IDLE;
            else if (c == "*") r.st = S_BLK_STAR;
            else begin
               if (c == 8'h0A && r.line < LineMax) r.line = r.line + 24'd1;
               r.st = S_BLK;
            end
         end
         S_STR: begin
            if (x.esc) begin
               r.esc = 1'b0;
               r = put(r, KindChar, c, 2'd0, 3'd0);
            end else if (c == 8'h22) begin
               r = end_token(r, TypeStr);
            end else if (c == 8'h0A) begin
               r = fail_restart(r, ErrNlQuote, c, n, rn);
            end else if (is_full(x.tl)) begin
               r = fail_restart(r, ErrStrLong, c, n, rn);
            end else begin
               r.tl = x.tl + TokLenW'(1);
               if (c == 8'h5C && n == 8'h22) r.esc = 1'b1;
               else r = put(r, KindChar, c, 2'd0, 3'd0);
            end
         end
         S_CHR_OPEN: begin
            if (c == 8'h0A) r = fail_restart(r, ErrNlChar, c, n, rn);
            else if (c == 8'h5C) r.st = S_CHR_ESC;
            else begin
               r = put(r, KindChar, c, 2'd0, 3'd0);
               r.st = S_CHR_CLOSE;
            end
         end
         S_CHR_ESC: begin
            if (c == 8'h0A) r = fail_restart(r, ErrNlChar, c, n, rn);
            else begin
               r = put(r, KindChar, (c == 8'h5C || c == 8'h27) ? c : 8'd0, 2'd0, 3'd0);
               r.st = S_CHR_CLOSE;
            end
         end
         S_CHR_CLOSE: begin
            if (c == 8'h27) begin
               r = put(r, KindChar, c, 2'd0, 3'd0);
               r = end_token(r, TypeInt);
            end else r = fail_restart(r, ErrNlChar, c, n, rn);
         end
         S_HEX_X: begin
            r = put(r, KindChar, c, 2'd0, 3'd0);
            r.tl = TokLenW'(2);
            if (is_hex(n)) r.st = S_HEX;
            else r = end_token(r, TypeInt);
         end
         S_HEX: begin
            if (is_full(x.tl)) r = fail_restart(r, ErrTokLong, c, n, rn);
            else begin
               r.tl = x.tl + TokLenW'(1);
               r = put(r, KindChar, c, 2'd0, 3'd0);
               if (!is_hex(n)) r = end_token(r, TypeInt);
            end
         end
         S_NUM: begin
            if (is_full(x.tl)) r = fail_restart(r, ErrTokLong, c, n, rn);
            else begin
               r.tl = x.tl + TokLenW'(1);
               if (c == ".") r.pt = 1'b1;
               r = put(r, KindChar, c, 2'd0, 3'd0);
               if (is_digit(n) || (n == "." && !r.pt)) r.st = S_NUM;
               else r = end_token(r, r.pt ? TypeReal : TypeInt);
            end
         end
         S_IDENT: begin
            if (is_full(x.tl)) r = fail_restart(r, ErrTokLong, c, n, rn);
            else begin
               r.tl = x.tl + TokLenW'(1);
               r = put(r, KindChar, c, 2'd0, 3'd0);
               if (n <= 8'd32 || is_single_op(n) || is_double_op(n))
                  r = end_token(r, TypeIdent);
               else r.st = S_IDENT;
            end
         end
         S_OP2: begin
            r = put(r, KindChar, c, 2'd0, 3'd0);
            r = end_token(r, TypeIdent);
         end
         default: r = idle_byte(r, c, n, rn);
      endcase
      return r;
   endfunction

endpackage

FILE: src/c_like_text_tokenizer.sv
// Streaming C-style tokenizer, top level: front scanner, bundle queue, result serializer.
// Depends on ctt_pkg, ctt_front, ctt_queue, ctt_back and c_like_text_tokenizer_macros.svh.
//
// One text byte enters per item and the scanner answers one byte late, using the new byte
// as lookahead. An item is taken every cycle in which req_full is low: the front end scans
// combinationally and drops all results of the item (up to four) into a four-entry bundle
// queue as one entry. req_full rises only when that queue holds four bundles. The back end
// hands out one result per rsp_pop, so an item that causes k results needs k pops; the
// output rate is one result per cycle while rsp_pop is high and rsp_empty low. The result
// on rsp_item is valid while rsp_empty is low, and last marks the final result of its item.
// csr_wdata sets newline reporting; write it only while the block is idle. An end_of_input
// item flushes the held byte, reports any open comment, string or character literal, emits
// end of stream and returns the scan state and line counter to reset.
`include "c_like_text_tokenizer_macros.svh"
module c_like_text_tokenizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  ctt_pkg::req_item_type req_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output ctt_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write,
   input  logic                  csr_wdata
);
   import ctt_pkg::*;

   logic       report_nl_ff, report_nl_in;
   logic       accept;
   logic       bundle_push;
   bundle_type bundle, head;
   logic       q_full, q_empty, head_pop;

   // hold the newline-mode register until written
   assign report_nl_in = csr_write ? csr_wdata : report_nl_ff;

   always_ff @(posedge clock) begin
      if (reset) report_nl_ff <= 1'b0;
      else       report_nl_ff <= report_nl_in;
   end

   // take an item whenever the queue has room for its bundle
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ctt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .item            (req_item),
      .report_newlines (report_nl_ff),
      .bundle_push     (bundle_push),
      .bundle          (bundle)
   );

   ctt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (bundle_push),
      .wdata (bundle),
      .pop   (head_pop),
      .rdata (head),
      .full  (q_full),
      .empty (q_empty)
   );

   ctt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (q_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

   `CTT_ASSERT_NOW(a_bundle_nonempty, bundle_push, bundle.cnt != 3'd0, "empty bundle queued")
   `CTT_ASSERT_NOW(a_eos_last, !rsp_empty && rsp_item.kind == KindEos, rsp_item.last, "eos not last")
   `CTT_ASSERT_NEXT(a_rest_of_item, !rsp_empty && rsp_pop && !rsp_item.last, !rsp_empty, "item cut short")
   `CTT_ASSERT_NOW(a_head_count, !q_empty, head.cnt != 3'd0 && head.cnt <= 3'(MaxRes), "bad bundle count")

endmodule

FILE: src/ctt_front.sv
// Front end: holds the pending byte and scan state, turns one item into a result bundle.
// Depends on ctt_pkg.
module ctt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ctt_pkg::req_item_type item,
   input  logic                report_newlines,
   output logic                bundle_push,
   output ctt_pkg::bundle_type bundle
);
   import ctt_pkg::*;

   logic [7:0]         held_byte_ff, held_byte_in;
   logic               held_valid_ff, held_valid_in;
   scan_state_type     state_ff, state_in;
   logic [TokLenW-1:0] tok_len_ff, tok_len_in;
   logic               point_ff, point_in;
   logic               esc_ff, esc_in;
   logic [23:0]        line_ff, line_in;

   ctx_type cur, nxt;

   always_comb begin
      cur = '{st: state_ff, tl: tok_len_ff, pt: point_ff, esc: esc_ff, line: line_ff,
              bnd: '0};
      nxt = cur;
      if (!item.end_of_input) begin
         if (held_valid_ff) nxt = scan(cur, held_byte_ff, item.char_in, report_newlines);
      end else begin
         // flush: scan the held byte against a zero lookahead, then report open constructs
         if (held_valid_ff) nxt = scan(cur, held_byte_ff, 8'd0, report_newlines);
         if (nxt.st == S_BLK_OPEN || nxt.st == S_BLK || nxt.st == S_BLK_STAR)
            nxt = put(nxt, KindError, 8'd0, 2'd0, ErrEndComment);
         else if (nxt.st == S_STR)
            nxt = put(nxt, KindError, 8'd0, 2'd0, ErrEndQuote);
         else if (nxt.st == S_CHR_OPEN || nxt.st == S_CHR_ESC || nxt.st == S_CHR_CLOSE)
            nxt = put(nxt, KindError, 8'd0, 2'd0, ErrNlChar);
         nxt = put(nxt, KindEos, 8'd0, 2'd0, 3'd0);
      end
   end

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      state_in      = state_ff;
      tok_len_in    = tok_len_ff;
      point_in      = point_ff;
      esc_in        = esc_ff;
      line_in       = line_ff;
      if (accept) begin
         if (item.end_of_input) begin
            held_byte_in  = 8'd0;
            held_valid_in = 1'b0;
            state_in      = S_IDLE;
            tok_len_in    = '0;
            point_in      = 1'b0;
            esc_in        = 1'b0;
            line_in       = 24'd1;
         end else begin
            held_byte_in  = item.char_in;
            held_valid_in = 1'b1;
            state_in      = nxt.st;
            tok_len_in    = nxt.tl;
            point_in      = nxt.pt;
            esc_in        = nxt.esc;
            line_in       = nxt.line;
         end
      end
   end

   assign bundle_push = accept && (nxt.bnd.cnt != 3'd0);
   assign bundle      = nxt.bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         state_ff      <= S_IDLE;
         tok_len_ff    <= '0;
         point_ff      <= 1'b0;
         esc_ff        <= 1'b0;
         line_ff       <= 24'd1;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         state_ff      <= state_in;
         tok_len_ff    <= tok_len_in;
         point_ff      <= point_in;
         esc_ff        <= esc_in;
         line_ff       <= line_in;
      end
   end
endmodule

FILE: src/ctt_queue.sv
// Short bundle queue between front and back end.
// Depends on ctt_pkg.
module ctt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctt_pkg::bundle_type wdata,
   input  logic                pop,
   output ctt_pkg::bundle_type rdata,
   output logic                full,
   output logic                empty
);
   import ctt_pkg::*;

   localparam int PtrW = $clog2(QDepth);

   bundle_type            mem_ff [QDepth];
   logic [PtrW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]         cnt_ff, cnt_in;

   assign full  = cnt_ff == (PtrW+1)'(QDepth);
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = wr_ff + PtrW'(1);
      if (pop)  rd_in = rd_ff + PtrW'(1);
      if (push && !pop) cnt_in = cnt_ff + (PtrW+1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (PtrW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: src/ctt_back.sv
// Back end: walks the head bundle and offers its results one at a time.
// Depends on ctt_pkg.
module ctt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ctt_pkg::bundle_type   head,
   input  logic                  head_empty,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output ctt_pkg::rsp_item_type rsp_item
);
   import ctt_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   res_type    cur;

   assign cur       = head.res[idx_ff];
   assign is_last   = idx_ff == (head.cnt[1:0] - 2'd1);
   assign rsp_empty = head_empty;
   assign head_pop  = rsp_pop && !head_empty && is_last;
   assign rsp_item  = '{kind: cur.kind, out_char: cur.ch, token_type: cur.ttype,
                        error_code: cur.err, line_number: cur.line, last: is_last};

   always_comb begin
      idx_in = idx_ff;
      if (rsp_pop && !head_empty) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else       idx_ff <= idx_in;
   end
endmodule
